// File: hdl/erng_pkg.sv
package erng_pkg;

	localparam logic [31:0] SEED_VALUE = 32'h0000_ACE1;
	localparam logic [30:0] LCG_MUL    = 31'(64'd1103515245);
	localparam logic [30:0] LCG_MUL3   = 31'(64'd3 * 64'd1103515245);
	localparam logic [30:0] LCG_ADD    = 31'd12345;

	localparam int MUL_STEPS = 16;
	localparam int DIV_STEPS = 32;

	localparam logic KIND_MIX  = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

// File: hdl/erng_div.sv
module erng_div (
	input  logic              clk,
	input  logic              arst_n,
	input  erng_pkg::div_req_t req,
	output erng_pkg::div_rsp_t rsp
);
	import erng_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      dvd_q;
	logic [31:0]      rem_q;
	logic [31:0]      div_q;
	logic [32:0]      shifted;
	logic [33:0]      trial;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, dvd_q[31]};
	assign trial   = {1'b0, shifted} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial[31:0];
			end else begin
				rem_q <= shifted[31:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// File: hdl/entropy_mixed_random_range.sv
// Range random generator with entropy mixing. A mix item (tuser low) XORs
// entropy_byte into the 32-bit generator word and stirs it with xorshift
// steps 13, 17, 5; it is taken while idle and gives no result. A draw item
// (tuser high) advances the word by the 31-bit LCG and returns a value in
// the inclusive signed range given by the two bounds, in either order. The
// LCG multiply runs two multiplier bits per cycle and the range reduction
// is a bit-serial restoring remainder unit, so a draw blocks the input
// through the multiply, the remainder and the output load, and skips the
// remainder when the bounds span the whole 32-bit range. A finished
// result waits in the output register while the next item is taken.
module entropy_mixed_random_range (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // entropy_byte, range_low, range_high
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // random_value
);
	import erng_pkg::*;

	localparam int CNT_W = $clog2(MUL_STEPS);

	state_t           state_q;
	state_t           state_d;
	logic [31:0]      gen_q;
	logic [31:0]      mcand_q;
	logic [30:0]      mul_q;
	logic [30:0]      mul3_q;
	logic [30:0]      acc_q;
	logic [30:0]      acc_nxt;
	logic [30:0]      term;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      lo_q;
	logic [31:0]      hi_q;
	logic [31:0]      span;
	logic [31:0]      res_q;
	logic [31:0]      out_q;
	logic             out_valid_q;
	logic             in_acc;
	logic             mul_last;
	logic             load_out;
	logic [7:0]       in_byte;
	logic [31:0]      in_lo;
	logic [31:0]      in_hi;
	logic             swap;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	function automatic logic [31:0] mix(input logic [31:0] s);
		logic [31:0] t;
		t = s ^ (s << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

	assign in_byte  = s_axis_tdata[7:0];
	assign in_lo    = s_axis_tdata[39:8];
	assign in_hi    = s_axis_tdata[71:40];
	assign swap     = $signed(in_lo) > $signed(in_hi);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign mul_last = (cnt_q == CNT_W'(MUL_STEPS - 1));
	assign span     = hi_q - lo_q + 32'd1;

	// radix-4 digit of the multiplier
	always_comb begin
		unique case (mcand_q[1:0])
			2'd0: term = '0;
			2'd1: term = mul_q;
			2'd2: term = {mul_q[29:0], 1'b0};
			2'd3: term = mul3_q;
		endcase
	end
	assign acc_nxt = acc_q + term;

	always_comb begin
		state_d          = state_q;
		s_axis_tready    = 1'b0;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = {1'b0, acc_nxt};
		div_req.divisor  = span;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (in_acc && s_axis_tuser == KIND_DRAW) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_last) begin
					if (span == '0) begin
						state_d = ST_OUT;
					end else begin
						div_req.start = 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gen_q       <= SEED_VALUE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc && s_axis_tuser == KIND_MIX) begin
				gen_q <= mix(gen_q ^ {24'd0, in_byte});
			end else if (state_q == ST_MUL && mul_last) begin
				gen_q <= {1'b0, acc_nxt};
			end
			if (state_q == ST_MUL) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser == KIND_DRAW) begin
			lo_q    <= swap ? in_hi : in_lo;
			hi_q    <= swap ? in_lo : in_hi;
			mcand_q <= gen_q;
			mul_q   <= LCG_MUL;
			mul3_q  <= LCG_MUL3;
			acc_q   <= LCG_ADD;
		end else if (state_q == ST_MUL) begin
			mcand_q <= {2'b00, mcand_q[31:2]};
			mul_q   <= {mul_q[28:0], 2'b00};
			mul3_q  <= {mul3_q[28:0], 2'b00};
			acc_q   <= acc_nxt;
		end
		// full range: no reduction
		if (state_q == ST_MUL && mul_last) begin
			res_q <= {1'b0, acc_nxt} + lo_q;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			res_q <= div_rsp.rem + lo_q;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	erng_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

// File: hdl/erng_checker.sv
module erng_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	import erng_pkg::*;

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	// a draw item blocks the input while it is worked on
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_DRAW |=> !s_axis_tready)
		else $error("input ready during a draw");

	// a mix item leaves the input free
	a_mix_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_MIX |=> s_axis_tready)
		else $error("input blocked after a mix item");

	// a new result only appears at the end of a draw
	a_out_from_draw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without a draw");

endmodule

bind entropy_mixed_random_range erng_checker u_erng_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
